// ===== rtl/octn_pkg.sv =====
// ----------------------------------------------------------------------------
// octn_pkg: shared constants and types for the octahedral normal decoder
// Divider and root widths follow from OUT_FRAC_BITS; front widths are fixed.
// ----------------------------------------------------------------------------
package octn_pkg;

    // output fraction bits, valid range 8..14 (2^F must fit the signed OUT_W field)
    localparam int OUT_FRAC_BITS = 14;

    localparam int CODE_W = 16;                 // octahedral code width
    localparam int MAG_W  = 16;                 // integer component magnitude
    localparam int SQ_W   = 2 * MAG_W;          // squared magnitude
    localparam int S_W    = 32;                 // squared length, <= 65535^2
    localparam int OUT_W  = 16;                 // result field width

    localparam logic [MAG_W:0] CODE_MAX = 17'h0FFFF;

    // floor(c^2 * 2^(2F+2) / s) needs 2F+3 bits, one per divider stage
    localparam int QUO_W = 2 * OUT_FRAC_BITS + 3;
    // isqrt of the quotient is at most 2^(F+1): F+2 bits, one per root stage
    localparam int ROOT_W = OUT_FRAC_BITS + 2;
    localparam int RAD_W  = 2 * ROOT_W;
    // signed workspace wide enough for any root before truncation to OUT_W
    localparam int EXT_W  = 34;

    localparam logic [QUO_W-1:0]  QUO_MAX  = QUO_W'(1) << (QUO_W - 1);
    localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(1) << (ROOT_W - 1);

    localparam int FRONT_LAT = 4;
    localparam int PIPE_LAT  = FRONT_LAT + QUO_W + ROOT_W + 1;

    // per-lane control that travels with the data
    typedef struct packed {
        logic valid;
        logic neg;
    } lane_ctl_t;

endpackage

// ===== rtl/oct32_normal_decode_core.sv =====
// ----------------------------------------------------------------------------
// oct32_normal_decode_core: octahedral 2x16-bit normal decoder
// Throughput: one transaction per cycle; busy stays low, start is always taken.
// Stages: 4 front stages, 2F+3 divider stages, F+2 root stages, 1 output stage.
// Results cannot be stalled: each one shows on the result ports for one cycle.
// Reset clears every valid bit at once; the pipeline is empty right after it.
// ----------------------------------------------------------------------------
module oct32_normal_decode_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [octn_pkg::CODE_W-1:0]       enc_x,
    input  logic [octn_pkg::CODE_W-1:0]       enc_y,
    output logic                              done,
    output logic signed [octn_pkg::OUT_W-1:0] norm_x,
    output logic signed [octn_pkg::OUT_W-1:0] norm_y,
    output logic signed [octn_pkg::OUT_W-1:0] norm_z
);
    import octn_pkg::*;

    // Each component magnitude is round(|c| * 2^F / sqrt(s)) with ties away
    // from zero. With q = isqrt(floor(c^2 * 2^(2F+2) / s)) = floor(2|c|2^F/len),
    // that magnitude is (q + 1) >> 1, which never exceeds 2^F.

    lane_ctl_t         ctl_fx, ctl_fy, ctl_fz;
    lane_ctl_t         ctl_dx, ctl_dy, ctl_dz;
    lane_ctl_t         ctl_rx, ctl_ry, ctl_rz;
    logic [SQ_W-1:0]   c2_x, c2_y, c2_z;
    logic [S_W-1:0]    len2;
    logic [QUO_W-1:0]  quo_x, quo_y, quo_z;
    logic [ROOT_W-1:0] root_x, root_y, root_z;

    logic              done_reg;
    logic [OUT_W-1:0]  nx_reg, ny_reg, nz_reg;

    // the pipeline never holds off a transaction
    assign busy = 1'b0;

    octn_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .enc_x    (enc_x),
        .enc_y    (enc_y),
        .ctl_x    (ctl_fx),
        .ctl_y    (ctl_fy),
        .ctl_z    (ctl_fz),
        .c2_x     (c2_x),
        .c2_y     (c2_y),
        .c2_z     (c2_z),
        .s        (len2)
    );

    // one divider lane per component, all sharing the squared length
    octn_div u_div_x
    (
        .clk (clk), .rst_n (rst_n), .ctl_in (ctl_fx), .c2 (c2_x), .s (len2),
        .ctl_out (ctl_dx), .quo (quo_x)
    );
    octn_div u_div_y
    (
        .clk (clk), .rst_n (rst_n), .ctl_in (ctl_fy), .c2 (c2_y), .s (len2),
        .ctl_out (ctl_dy), .quo (quo_y)
    );
    octn_div u_div_z
    (
        .clk (clk), .rst_n (rst_n), .ctl_in (ctl_fz), .c2 (c2_z), .s (len2),
        .ctl_out (ctl_dz), .quo (quo_z)
    );

    octn_sqrt u_sqrt_x
    (
        .clk (clk), .rst_n (rst_n), .ctl_in (ctl_dx), .rad (quo_x),
        .ctl_out (ctl_rx), .root (root_x)
    );
    octn_sqrt u_sqrt_y
    (
        .clk (clk), .rst_n (rst_n), .ctl_in (ctl_dy), .rad (quo_y),
        .ctl_out (ctl_ry), .root (root_y)
    );
    octn_sqrt u_sqrt_z
    (
        .clk (clk), .rst_n (rst_n), .ctl_in (ctl_dz), .rad (quo_z),
        .ctl_out (ctl_rz), .root (root_z)
    );

    // round the doubled root, apply the sign, truncate to the field width
    function automatic logic [OUT_W-1:0] encode_comp(input logic [ROOT_W-1:0] q,
                                                     input logic neg);
        logic [ROOT_W:0]  q_inc;
        logic [EXT_W-1:0] mag;
        logic [EXT_W-1:0] val;
        q_inc = {1'b0, q} + {{ROOT_W{1'b0}}, 1'b1};
        mag   = EXT_W'(q_inc[ROOT_W:1]);
        val   = neg ? (~mag + EXT_W'(1)) : mag;
        return val[OUT_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_rx.valid;
        end
    end

    // hold results only for the strobe cycle; no reset on payload
    always_ff @(posedge clk)
    begin
        nx_reg <= encode_comp(root_x, ctl_rx.neg);
        ny_reg <= encode_comp(root_y, ctl_ry.neg);
        nz_reg <= encode_comp(root_z, ctl_rz.neg);
    end

    assign done   = done_reg;
    assign norm_x = nx_reg;
    assign norm_y = ny_reg;
    assign norm_z = nz_reg;

`ifndef NO_ASSERTIONS
    // the three lanes advance in lockstep
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_rx.valid == ctl_ry.valid) && (ctl_rx.valid == ctl_rz.valid))
        else $error("component lanes out of step");
`endif

endmodule

// ===== rtl/octn_front.sv =====
// ----------------------------------------------------------------------------
// octn_front: code unpack, hemisphere fold, squares and squared length
// Four register stages; one transaction enters per cycle.
// ----------------------------------------------------------------------------
module octn_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [octn_pkg::CODE_W-1:0] enc_x,
    input  logic [octn_pkg::CODE_W-1:0] enc_y,
    output octn_pkg::lane_ctl_t        ctl_x,
    output octn_pkg::lane_ctl_t        ctl_y,
    output octn_pkg::lane_ctl_t        ctl_z,
    output logic [octn_pkg::SQ_W-1:0]  c2_x,
    output logic [octn_pkg::SQ_W-1:0]  c2_y,
    output logic [octn_pkg::SQ_W-1:0]  c2_z,
    output logic [octn_pkg::S_W-1:0]   s
);
    import octn_pkg::*;

    // stage 1: magnitudes and signs of the numerators 2c - 65535
    logic             v1_reg;
    logic [MAG_W-1:0] abx_reg, aby_reg, abx_next, aby_next;
    logic             sx1_reg, sy1_reg;
    // stage 2: folded vector magnitudes
    logic             v2_reg;
    logic [MAG_W-1:0] mx_reg, my_reg, mz_reg, mx_next, my_next, mz_next;
    logic             sx2_reg, sy2_reg, sz2_reg, fold_next;
    // stage 3: squares
    logic             v3_reg;
    logic [SQ_W-1:0]  qx_reg, qy_reg, qz_reg;
    logic             sx3_reg, sy3_reg, sz3_reg;
    // stage 4: squared length
    logic             v4_reg;
    logic [SQ_W-1:0]  c2x_reg, c2y_reg, c2z_reg;
    logic [S_W-1:0]   s_reg;
    logic [S_W+1:0]   s_sum;
    logic             sx4_reg, sy4_reg, sz4_reg;
    logic [MAG_W:0]   ex2, ey2, dx, dy, sum17, fx, fy, fz;

    always_comb
    begin
        ex2 = {enc_x, 1'b0};
        ey2 = {enc_y, 1'b0};
        dx  = enc_x[CODE_W-1] ? (ex2 - CODE_MAX) : (CODE_MAX - ex2);
        dy  = enc_y[CODE_W-1] ? (ey2 - CODE_MAX) : (CODE_MAX - ey2);
        abx_next = dx[MAG_W-1:0];
        aby_next = dy[MAG_W-1:0];
    end

    always_comb
    begin
        sum17     = {1'b0, abx_reg} + {1'b0, aby_reg};
        fold_next = (sum17 > CODE_MAX);
        fx        = CODE_MAX - {1'b0, aby_reg};
        fy        = CODE_MAX - {1'b0, abx_reg};
        fz        = fold_next ? (sum17 - CODE_MAX) : (CODE_MAX - sum17);
        mx_next   = fold_next ? fx[MAG_W-1:0] : abx_reg;
        my_next   = fold_next ? fy[MAG_W-1:0] : aby_reg;
        mz_next   = fz[MAG_W-1:0];
    end

    assign s_sum = {2'b00, qx_reg} + {2'b00, qy_reg} + {2'b00, qz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        abx_reg <= abx_next;
        aby_reg <= aby_next;
        sx1_reg <= ~enc_x[CODE_W-1];
        sy1_reg <= ~enc_y[CODE_W-1];

        mx_reg  <= mx_next;
        my_reg  <= my_next;
        mz_reg  <= mz_next;
        sx2_reg <= sx1_reg;
        sy2_reg <= sy1_reg;
        sz2_reg <= fold_next;

        qx_reg  <= mx_reg * mx_reg;
        qy_reg  <= my_reg * my_reg;
        qz_reg  <= mz_reg * mz_reg;
        sx3_reg <= sx2_reg;
        sy3_reg <= sy2_reg;
        sz3_reg <= sz2_reg;

        // on the octahedron |x|+|y|+|z| = 65535, so the sum fits S_W bits
        s_reg   <= s_sum[S_W-1:0];
        c2x_reg <= qx_reg;
        c2y_reg <= qy_reg;
        c2z_reg <= qz_reg;
        sx4_reg <= sx3_reg;
        sy4_reg <= sy3_reg;
        sz4_reg <= sz3_reg;
    end

    assign ctl_x = '{valid: v4_reg, neg: sx4_reg};
    assign ctl_y = '{valid: v4_reg, neg: sy4_reg};
    assign ctl_z = '{valid: v4_reg, neg: sz4_reg};
    assign c2_x  = c2x_reg;
    assign c2_y  = c2y_reg;
    assign c2_z  = c2z_reg;
    assign s     = s_reg;

`ifndef NO_ASSERTIONS
    // each squared component is bounded by the squared length
    a_comp_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (c2x_reg <= s_reg) && (c2y_reg <= s_reg) && (c2z_reg <= s_reg))
        else $error("component square exceeds squared length");
`endif

endmodule

// ===== rtl/octn_div.sv =====
// ----------------------------------------------------------------------------
// octn_div: pipelined restoring divider, one quotient bit per stage
// Computes floor(c2 * 2^(2F+2) / s) for one lane.
// ----------------------------------------------------------------------------
module octn_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  octn_pkg::lane_ctl_t         ctl_in,
    input  logic [octn_pkg::SQ_W-1:0]   c2,
    input  logic [octn_pkg::S_W-1:0]    s,
    output octn_pkg::lane_ctl_t         ctl_out,
    output logic [octn_pkg::QUO_W-1:0]  quo
);
    import octn_pkg::*;

    localparam int LAST = QUO_W - 1;

    lane_ctl_t        ctl_reg [QUO_W];
    logic [S_W-1:0]   rem_reg [QUO_W];
    logic [S_W-1:0]   div_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [S_W:0]     trial;
        logic [S_W:0]     diff;
        logic [S_W-1:0]   div_src;
        logic [QUO_W-1:0] quo_prev;
        lane_ctl_t        ctl_src;
        logic             take;
        logic [S_W-1:0]   rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            // c2 >> 1 is below s, so the first trial is c2 itself
            assign trial    = {1'b0, c2};
            assign div_src  = s;
            assign quo_prev = '0;
            assign ctl_src  = ctl_in;
        end
        else
        begin : g_next
            assign trial    = {rem_reg[k-1], 1'b0};
            assign div_src  = div_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign ctl_src  = ctl_reg[k-1];
        end

        always_comb
        begin
            diff     = trial - {1'b0, div_src};
            take     = (trial >= {1'b0, div_src});
            rem_next = take ? diff[S_W-1:0] : trial[S_W-1:0];
            quo_next = {quo_prev[QUO_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            div_reg[k] <= div_src;
            quo_reg[k] <= quo_next;
        end
    end

    assign ctl_out = ctl_reg[LAST];
    assign quo     = quo_reg[LAST];

`ifndef NO_ASSERTIONS
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[LAST].valid |-> (rem_reg[LAST] < div_reg[LAST]))
        else $error("divider remainder not below divisor");
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[LAST].valid |-> (quo_reg[LAST] <= QUO_MAX))
        else $error("quotient exceeds 2^(2F+2)");
`endif

endmodule

// ===== rtl/octn_sqrt.sv =====
// ----------------------------------------------------------------------------
// octn_sqrt: pipelined restoring integer square root, one root bit per stage
// Floor square root of the divider quotient for one lane.
// ----------------------------------------------------------------------------
module octn_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  octn_pkg::lane_ctl_t         ctl_in,
    input  logic [octn_pkg::QUO_W-1:0]  rad,
    output octn_pkg::lane_ctl_t         ctl_out,
    output logic [octn_pkg::ROOT_W-1:0] root
);
    import octn_pkg::*;

    localparam int LAST  = ROOT_W - 1;
    localparam int REM_W = ROOT_W + 1;
    localparam int TR_W  = ROOT_W + 3;

    lane_ctl_t         ctl_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic [RAD_W-1:0]  rad_src;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        lane_ctl_t         ctl_src;
        logic [TR_W-1:0]   trial;
        logic [TR_W-1:0]   tsub;
        logic [TR_W-1:0]   diff;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rad_src   = {{(RAD_W - QUO_W){1'b0}}, rad};
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign ctl_src   = ctl_in;
        end
        else
        begin : g_next
            assign rad_src   = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign ctl_src   = ctl_reg[k-1];
        end

        always_comb
        begin
            // bring down the next pair of radicand bits, try root*4+1
            trial     = {rem_prev, rad_src[RAD_W-1-2*k -: 2]};
            tsub      = {1'b0, root_prev, 2'b01};
            diff      = trial - tsub;
            take      = (trial >= tsub);
            rem_next  = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
            root_next = {root_prev[ROOT_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_src;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign ctl_out = ctl_reg[LAST];
    assign root    = root_reg[LAST];

`ifndef NO_ASSERTIONS
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[LAST].valid |-> (rem_reg[LAST] <= {root_reg[LAST], 1'b0}))
        else $error("square root remainder above 2*root");
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[LAST].valid |-> (root_reg[LAST] <= ROOT_MAX))
        else $error("root exceeds 2^(F+1)");
`endif

endmodule
